/* design/mca_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI chord arpeggiator package
// Shared types, codes and chord tables for the arpeggiator block.
// ----------------------------------------------------------------------------
package mca_pkg;

  localparam int IN_DW  = 48;
  localparam int OUT_DW = 24;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 20;

  localparam logic [CFG_AW-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CHORD   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_STEP    = 2'd2;

  localparam logic [1:0] PAT_PASS   = 2'd0;
  localparam logic [1:0] PAT_UP     = 2'd1;
  localparam logic [1:0] PAT_DOWN   = 2'd2;
  localparam logic [1:0] PAT_UPDOWN = 2'd3;

  localparam logic [2:0] CHORD_SINGLE  = 3'd0;
  localparam logic [2:0] CHORD_OCTAVE  = 3'd1;
  localparam logic [2:0] CHORD_POWER   = 3'd2;
  localparam logic [2:0] CHORD_TRIAD   = 3'd3;
  localparam logic [2:0] CHORD_SEVENTH = 3'd4;

  localparam logic [3:0] NOTE_ON_CMD  = 4'h9;
  localparam logic [3:0] NOTE_OFF_CMD = 4'h8;
  localparam logic [6:0] VEL_MAX      = 7'h7F;
  localparam logic [3:0] STEP_LAST    = 4'd11;

  localparam logic [19:0] STEP_RESET  = 20'd25200;
  // gate = floor(7 * step / 10) via reciprocal multiply
  localparam logic [23:0] GATE_RECIP  = 24'd13421773;
  localparam int          GATE_SHIFT  = 27;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MSG,
    OP_GATE,
    OP_STEP,
    OP_STEP_ON
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   en;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic tick_skip;
    logic armed;
    logic step_go;
    logic split;
    logic emit;
  } dp_sts_t;

  typedef struct packed {
    logic push;
    logic flush;
  } ob_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
  } ob_sts_t;

  typedef struct packed {
    logic [7:0] data_two;
    logic [7:0] data_one;
    logic [7:0] status;
  } msg_t;

  function automatic logic [2:0] chord_size(input logic [2:0] cm);
    logic [2:0] r;
    case (cm)
      CHORD_SINGLE: r = 3'd1;
      CHORD_OCTAVE: r = 3'd2;
      CHORD_POWER:  r = 3'd3;
      CHORD_TRIAD:  r = 3'd3;
      default:      r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] chord_offset(input logic [2:0] cm, input logic [1:0] idx);
    logic [3:0] r;
    r = 4'd0;
    case (cm)
      CHORD_SINGLE: r = 4'd0;
      CHORD_OCTAVE: r = (idx == 2'd1) ? 4'd12 : 4'd0;
      CHORD_POWER: begin
        case (idx)
          2'd1:    r = 4'd7;
          2'd2:    r = 4'd12;
          default: r = 4'd0;
        endcase
      end
      CHORD_TRIAD: begin
        case (idx)
          2'd1:    r = 4'd4;
          2'd2:    r = 4'd7;
          default: r = 4'd0;
        endcase
      end
      default: begin
        case (idx)
          2'd1:    r = 4'd4;
          2'd2:    r = 4'd7;
          2'd3:    r = 4'd10;
          default: r = 4'd0;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] step_mod(input logic [3:0] step, input logic [2:0] cnt);
    logic [3:0] q;
    logic [1:0] r;
    if (step >= 4'd9) begin
      q = step - 4'd9;
    end else if (step >= 4'd6) begin
      q = step - 4'd6;
    end else if (step >= 4'd3) begin
      q = step - 4'd3;
    end else begin
      q = step;
    end
    case (cnt)
      3'd2:    r = {1'b0, step[0]};
      3'd3:    r = q[1:0];
      default: r = step[1:0];
    endcase
    return r;
  endfunction

  function automatic logic [1:0] chord_index(input logic [3:0] step, input logic [2:0] cnt,
                                             input logic [1:0] pat);
    logic [1:0] m;
    logic [3:0] p6;
    logic [1:0] r;
    r  = 2'd0;
    m  = step_mod(step, cnt);
    p6 = (step >= 4'd6) ? step - 4'd6 : step;
    if (cnt > 3'd1) begin
      case (pat)
        PAT_UP:   r = m;
        PAT_DOWN: r = 2'(cnt - 3'd1) - m;
        PAT_UPDOWN: begin
          case (cnt)
            3'd2:    r = {1'b0, step[0]};
            3'd3:    r = (step[1:0] == 2'd3) ? 2'd1 : step[1:0];
            default: r = (p6 < 4'd4) ? p6[1:0] : 2'(4'd6 - p6);
          endcase
        end
        default: r = 2'd0;
      endcase
    end
    return r;
  endfunction

endpackage

/* design/mca_obuf.sv */
// ----------------------------------------------------------------------------
// Arpeggiator output buffer
// One pending slot plus the output register; marks the final item of an input.
// ----------------------------------------------------------------------------
module mca_obuf import mca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ob_cmd_t           cmd_i,
  input  msg_t              msg_i,
  output ob_sts_t           sts_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_DW-1:0] m_axis_tdata_o,  // status, data one, data two
  output logic              m_axis_tlast_o   // last item of this input
);

  logic pend_valid_q, pend_valid_d;
  msg_t pend_q;
  logic out_valid_q, out_valid_d;
  msg_t out_q;
  logic last_q;
  logic out_free;
  logic load_out;

  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign sts_o.ready = !pend_valid_q || out_free;
  assign sts_o.done  = !pend_valid_q || out_free;
  assign load_out    = pend_valid_q && out_free && (cmd_i.push || cmd_i.flush);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    pend_valid_d = pend_valid_q;
    if (cmd_i.push) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.flush && out_free) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pend_q <= msg_i;
    end
    if (load_out) begin
      out_q  <= pend_q;
      last_q <= !cmd_i.push;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = last_q;

endmodule

/* design/mca_dp.sv */
// ----------------------------------------------------------------------------
// Arpeggiator datapath
// Configuration, held note, step and gate timers, and result formatting.
// ----------------------------------------------------------------------------
module mca_dp import mca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic [IN_DW-1:0]  in_data_i,
  input  logic              in_user_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output msg_t              msg_o
);

  logic [1:0]  pat_q;
  logic [2:0]  chord_q;
  logic [19:0] sf_q;
  logic [22:0] sf7_q;
  logic [19:0] gate_q;
  logic [46:0] gate_prod;

  logic        tick_q;
  logic [7:0]  st_q;
  logic [7:0]  d1_q;
  logic [7:0]  d2_q;
  logic [1:0]  len_q;
  logic [15:0] tf_q;

  logic        armed_q;
  logic [6:0]  key_q;
  logic [6:0]  vel_q;
  logic [3:0]  chan_q;
  logic        snd_valid_q;
  logic [6:0]  snd_q;
  logic [3:0]  step_q;
  logic [31:0] fts_q;
  logic [19:0] ftgo_q;

  logic [7:0]  d1m;
  logic [7:0]  d2m;
  logic        full_msg;
  logic        is_on;
  logic        is_off;
  logic        pass;
  logic [7:0]  note;
  logic        note_ok;
  logic        gate_hit;
  logic [32:0] fts_sub;
  logic [31:0] fts_dec;
  logic [31:0] fts_inc;
  logic [3:0]  step_next;
  msg_t        off_msg;
  msg_t        on_msg;
  msg_t        raw_msg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q   <= PAT_PASS;
      chord_q <= CHORD_SINGLE;
      sf_q    <= STEP_RESET;
      sf7_q   <= 23'(STEP_RESET) * 23'd7;
      gate_q  <= 20'd17640;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_PATTERN: pat_q <= cfg_wdata_i[1:0];
          CFG_CHORD: begin
            chord_q <= (cfg_wdata_i[2:0] > CHORD_SEVENTH) ? CHORD_SEVENTH : cfg_wdata_i[2:0];
          end
          CFG_STEP: sf_q <= (cfg_wdata_i == '0) ? 20'd1 : cfg_wdata_i;
          default: ;
        endcase
      end
      sf7_q  <= {sf_q, 3'b000} - {3'b000, sf_q};
      gate_q <= gate_prod[46:GATE_SHIFT];
    end
  end

  assign gate_prod = 47'(sf7_q) * 47'(GATE_RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.en && cmd_i.op == OP_LOAD) begin
      tick_q <= in_user_i;
      st_q   <= in_data_i[7:0];
      d1_q   <= in_data_i[15:8];
      d2_q   <= in_data_i[23:16];
      len_q  <= in_data_i[25:24];
      tf_q   <= in_data_i[41:26];
    end
  end

  assign d1m      = (len_q > 2'd1) ? d1_q : 8'd0;
  assign d2m      = (len_q == 2'd3) ? d2_q : 8'd0;
  assign full_msg = (len_q == 2'd3);
  assign is_on    = (st_q[7:4] == NOTE_ON_CMD) && full_msg && (d2m != 8'd0);
  assign is_off   = (st_q[7:4] == NOTE_OFF_CMD) ||
                    ((st_q[7:4] == NOTE_ON_CMD) && full_msg && (d2m == 8'd0));
  assign pass     = (pat_q == PAT_PASS);

  assign note     = {1'b0, key_q} +
                    {4'b0000, chord_offset(chord_q,
                                           chord_index(step_q, chord_size(chord_q), pat_q))};
  assign note_ok  = !note[7];
  assign gate_hit = snd_valid_q && (ftgo_q <= {4'b0000, tf_q});

  assign fts_sub   = {fts_q[31], fts_q} - {17'd0, tf_q};
  assign fts_dec   = (fts_sub[32] != fts_sub[31]) ? 32'h8000_0000 : fts_sub[31:0];
  assign fts_inc   = fts_q + {12'd0, sf_q};
  assign step_next = (step_q == STEP_LAST) ? 4'd0 : step_q + 4'd1;

  assign off_msg = '{data_two: 8'd0, data_one: {1'b0, snd_q}, status: {NOTE_OFF_CMD, chan_q}};
  assign on_msg  = '{data_two: {1'b0, vel_q}, data_one: note, status: {NOTE_ON_CMD, chan_q}};
  assign raw_msg = '{data_two: is_off ? 8'd0 : d2m, data_one: d1m, status: st_q};

  always_comb begin
    sts_o.is_tick   = tick_q;
    sts_o.tick_skip = (tf_q == 16'd0) || pass;
    sts_o.armed     = armed_q;
    sts_o.step_go   = fts_q[31] || (fts_q == 32'd0);
    sts_o.split     = note_ok && snd_valid_q;
    sts_o.emit      = 1'b0;
    msg_o           = raw_msg;
    case (cmd_i.op)
      OP_MSG: begin
        if (len_q == 2'd0) begin
          sts_o.emit = 1'b0;
        end else if (is_on && !pass) begin
          sts_o.emit = snd_valid_q;
          msg_o      = off_msg;
        end else if (is_off) begin
          sts_o.emit = pass;
        end else begin
          sts_o.emit = 1'b1;
        end
      end
      OP_GATE: begin
        sts_o.emit = gate_hit;
        msg_o      = off_msg;
      end
      OP_STEP: begin
        sts_o.emit = note_ok;
        msg_o      = snd_valid_q ? off_msg : on_msg;
      end
      OP_STEP_ON: begin
        sts_o.emit = 1'b1;
        msg_o      = on_msg;
      end
      default: sts_o.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      key_q       <= '0;
      vel_q       <= '0;
      chan_q      <= '0;
      snd_valid_q <= 1'b0;
      snd_q       <= '0;
      step_q      <= '0;
      fts_q       <= '0;
      ftgo_q      <= '0;
    end else if (cmd_i.en) begin
      case (cmd_i.op)
        OP_MSG: begin
          if (len_q != 2'd0 && !pass) begin
            if (is_on) begin
              snd_valid_q <= 1'b0;
              armed_q     <= 1'b1;
              key_q       <= d1m[6:0];
              vel_q       <= d2m[7] ? VEL_MAX : d2m[6:0];
              chan_q      <= st_q[3:0];
              step_q      <= '0;
              fts_q       <= '0;
              ftgo_q      <= '0;
            end else if (is_off && armed_q && key_q == d1m[6:0]) begin
              armed_q <= 1'b0;
            end
          end
        end
        OP_GATE: begin
          if (snd_valid_q) begin
            if (gate_hit) begin
              snd_valid_q <= 1'b0;
              ftgo_q      <= '0;
            end else begin
              ftgo_q <= ftgo_q - {4'b0000, tf_q};
            end
          end
          if (armed_q) begin
            fts_q <= fts_dec;
          end
        end
        OP_STEP: begin
          if (note_ok && snd_valid_q) begin
            snd_valid_q <= 1'b0;
          end else begin
            if (note_ok) begin
              snd_valid_q <= 1'b1;
              snd_q       <= note[6:0];
              ftgo_q      <= gate_q;
            end
            step_q <= step_next;
            fts_q  <= fts_inc;
          end
        end
        OP_STEP_ON: begin
          snd_valid_q <= 1'b1;
          snd_q       <= note[6:0];
          ftgo_q      <= gate_q;
          step_q      <= step_next;
          fts_q       <= fts_inc;
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/mca_ctrl.sv */
// ----------------------------------------------------------------------------
// Arpeggiator controller
// Sequences message handling, gate check and chord steps; counts results.
// ----------------------------------------------------------------------------
module mca_ctrl import mca_pkg::*; #(
  parameter int MAX_RESULTS = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output dp_cmd_t dp_cmd_o,
  input  dp_sts_t dp_sts_i,
  output ob_cmd_t ob_cmd_o,
  input  ob_sts_t ob_sts_i
);

  localparam int NW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_GATE,
    S_STEP,
    S_STEP_ON,
    S_FLUSH
  } state_e;

  state_e        state_q, state_d;
  logic [NW-1:0] n_q, n_d;
  logic          room;
  logic          stall;

  assign room  = (n_q < NW'(MAX_RESULTS));
  assign stall = dp_sts_i.emit && room && !ob_sts_i.ready;

  always_comb begin
    dp_cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE:     dp_cmd_o.op = OP_LOAD;
      S_DISPATCH: dp_cmd_o.op = dp_sts_i.is_tick ? OP_NONE : OP_MSG;
      S_GATE:     dp_cmd_o.op = dp_sts_i.tick_skip ? OP_NONE : OP_GATE;
      S_STEP:     dp_cmd_o.op = (dp_sts_i.step_go && room) ? OP_STEP : OP_NONE;
      S_STEP_ON:  dp_cmd_o.op = OP_STEP_ON;
      default:    dp_cmd_o.op = OP_NONE;
    endcase
    state_d        = state_q;
    n_d            = n_q;
    in_ready_o     = 1'b0;
    dp_cmd_o.en    = 1'b0;
    ob_cmd_o.flush = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        dp_cmd_o.en = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (dp_sts_i.is_tick) begin
          state_d = S_GATE;
        end else begin
          dp_cmd_o.en = !stall;
          if (!stall) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_GATE: begin
        if (dp_sts_i.tick_skip) begin
          state_d = S_FLUSH;
        end else begin
          dp_cmd_o.en = !stall;
          if (!stall) begin
            state_d = dp_sts_i.armed ? S_STEP : S_FLUSH;
          end
        end
      end
      S_STEP: begin
        if (!dp_sts_i.step_go || !room) begin
          state_d = S_FLUSH;
        end else begin
          dp_cmd_o.en = !stall;
          if (!stall) begin
            state_d = dp_sts_i.split ? S_STEP_ON : S_STEP;
          end
        end
      end
      S_STEP_ON: begin
        dp_cmd_o.en = !stall;
        if (!stall) begin
          state_d = S_STEP;
        end
      end
      S_FLUSH: begin
        ob_cmd_o.flush = 1'b1;
        if (ob_sts_i.done) begin
          state_d = S_IDLE;
          n_d     = '0;
        end
      end
      default: state_d = S_IDLE;
    endcase
    ob_cmd_o.push = dp_cmd_o.en && dp_sts_i.emit && room;
    if (ob_cmd_o.push) begin
      n_d = n_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  a_push_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cmd_o.push |-> ob_sts_i.ready)
    else $error("result pushed while output buffer full");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_RESULTS))
    else $error("result count above limit");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (n_q == '0))
    else $error("result count not cleared in idle");

  a_flush_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && !ob_sts_i.done) |=> (state_q == S_FLUSH))
    else $error("left flush with pending result");

endmodule

/* design/midi_chord_arpeggiator.sv */
// ----------------------------------------------------------------------------
// MIDI chord arpeggiator
// Monophonic arpeggiator: note messages arm it, timing ticks step chord notes.
//
//   channel  direction  tdata / tuser                                  handshake
//   s_axis   in         tdata: status, data one, data two, len, frames  tvalid/tready
//                       tuser: opcode (0 message, 1 tick)
//   m_axis   out        tdata: status, data one, data two; tlast        tvalid/tready
//   cfg      in         index 0 pattern, 1 chord, 2 step frames         cfg_we_i
//
// A message is loaded, handled and flushed; a tick is loaded, gate-checked and,
// when armed, walks the chord steps (with an extra state for each step that
// closes a sounding note first) before its flush. Results pass through a
// pending slot and the output register; when both are full the sequencer stalls in place.
// Reset clears the held note, timers and all control; configuration returns
// to passthrough, single note, 25200 frames per step.
// ----------------------------------------------------------------------------
module midi_chord_arpeggiator import mca_pkg::*; #(
  parameter int MAX_RESULTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // status_byte, data_one, data_two, msg_length, tick_frames, zero pad
  input  logic [IN_DW-1:0]  s_axis_tdata_i,
  input  logic              s_axis_tuser_i,  // opcode
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // out_status_byte, out_data_one, out_data_two
  output logic [OUT_DW-1:0] m_axis_tdata_o,
  output logic              m_axis_tlast_o   // out_last
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  ob_cmd_t ob_cmd;
  ob_sts_t ob_sts;
  msg_t    msg;

  mca_ctrl #(
    .MAX_RESULTS(MAX_RESULTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .dp_cmd_o   (dp_cmd),
    .dp_sts_i   (dp_sts),
    .ob_cmd_o   (ob_cmd),
    .ob_sts_i   (ob_sts)
  );

  mca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .msg_o       (msg)
  );

  mca_obuf u_obuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ob_cmd),
    .msg_i           (msg),
    .sts_o           (ob_sts),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
